>>> rtl/core/blank_run_to_tab_compressor_core_macros.svh
// assertion macros shared by the blank run compressor checkers
`ifndef BLANK_RUN_TO_TAB_COMPRESSOR_CORE_MACROS_SVH
`define BLANK_RUN_TO_TAB_COMPRESSOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BRTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("brtc: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define BRTC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("brtc: next-cycle check failed");

`endif

>>> rtl/core/brtc_pkg.sv
// package of the blank run to tab compressor: codes, types and constants
package brtc_pkg;

  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned COL_W           = 8;
  localparam int unsigned TW_W            = 5;
  localparam int unsigned COLUMN_LIMIT_DEF = 255;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  localparam logic [TW_W-1:0] TW_RESET = 5'd8;
  localparam logic [TW_W-1:0] TW_MIN   = 5'd8;
  localparam logic [TW_W-1:0] TW_MAX   = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD_TAB,
    ST_MOD_FLUSH,
    ST_FLUSH
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;       // input word taken this cycle
    logic mod_start;    // launch the remainder unit
    logic tab_finish;   // advance the column to the next tab stop
    logic flush_setup;  // load the flush cursor from the run start
    logic emit;         // put one word into the output register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_nl;        // input word is a newline
    logic in_tab;       // input word is a tab
    logic in_space;     // input word is a space
    logic in_run;       // a blank run is pending
    logic mod_done;     // remainder is ready
    logic out_free;     // output register can take a word
    logic emit_final;   // next emitted word is the closing one
  } dp_status_t;

endpackage

>>> rtl/core/blank_run_to_tab_compressor_core.sv
// A space only moves the column; a tab waits for the 8-step remainder unit.
// A plain character or newline goes via char_q to the output register once it is free.
// After a blank run, the run's tabs and spaces go out before the character.
// Output: one word per cycle from a single output register, stalls hold the flush cursor.
// Reset: asynchronous, active low; column and blank state clear, tab width returns to 8.
module blank_run_to_tab_compressor_core #(
  parameter int unsigned COLUMN_LIMIT = brtc_pkg::COLUMN_LIMIT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brtc_pkg::TW_W-1:0]    cfg_wdata_i,    // tab stop spacing
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [brtc_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] in_char
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [brtc_pkg::CHAR_W-1:0]  m_axis_tdata,   // [7:0] out_char
  output logic                         m_axis_tlast    // last
);

  brtc_pkg::ctrl_cmd_t  cmd;
  brtc_pkg::dp_status_t status;

  brtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  brtc_datapath #(
    .COLUMN_LIMIT (COLUMN_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_char_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> rtl/core/brtc_mod_unit.sv
// iterative remainder unit, one quotient bit per cycle
module brtc_mod_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [brtc_pkg::COL_W-1:0]    dividend_i,
  input  logic [brtc_pkg::TW_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [brtc_pkg::TW_W-2:0]     rem_o
);

  localparam int unsigned CNT_W = $clog2(brtc_pkg::COL_W);

  logic [brtc_pkg::COL_W-1:0] dvd_q, dvd_d;
  logic [brtc_pkg::TW_W-2:0]  rem_q, rem_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [brtc_pkg::TW_W-1:0]  trial;
  logic [brtc_pkg::TW_W-1:0]  diff;

  // restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[brtc_pkg::COL_W-1]};
  assign diff  = trial - divisor_i;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[brtc_pkg::COL_W-2:0], 1'b0};
      rem_d = (trial >= divisor_i) ? diff[brtc_pkg::TW_W-2:0] : trial[brtc_pkg::TW_W-2:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(brtc_pkg::COL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/core/brtc_datapath.sv
// datapath: column tracking, blank run state, flush cursor and output register
module brtc_datapath #(
  parameter int unsigned COLUMN_LIMIT = brtc_pkg::COLUMN_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brtc_pkg::TW_W-1:0]     cfg_wdata_i,
  input  logic [brtc_pkg::CHAR_W-1:0]   in_char_i,
  input  brtc_pkg::ctrl_cmd_t           cmd_i,
  output brtc_pkg::dp_status_t          status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [brtc_pkg::CHAR_W-1:0]   out_char_o,
  output logic                          out_last_o
);

  localparam int unsigned CW = brtc_pkg::COL_W;
  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] LIMIT    = SW'(COLUMN_LIMIT);
  localparam logic [SW-1:0] STOP_OFF = '1;

  logic [brtc_pkg::TW_W-1:0]   tw_q, tw_d;
  logic [brtc_pkg::TW_W-1:0]   width;
  logic [CW-1:0]               col_q, col_d;
  logic                        run_q, run_d;
  logic [CW-1:0]               bstart_q, bstart_d;
  logic [CW-1:0]               pos_q, pos_d;
  logic [SW-1:0]               stop_q, stop_d;
  logic [brtc_pkg::CHAR_W-1:0] char_q, char_d;
  logic                        ovalid_q, ovalid_d;
  logic [brtc_pkg::CHAR_W-1:0] ochar_q, ochar_d;
  logic                        olast_q, olast_d;
  logic                        in_nl, in_tab, in_space;
  logic                        tab_due, space_due;
  logic                        mod_done;
  logic [brtc_pkg::TW_W-2:0]   rem;
  logic [CW-1:0]               mod_dvd;
  logic [SW-1:0]               col_tab;
  logic [SW-1:0]               col_inc;
  logic [SW-1:0]               run_stop;

  function automatic logic [CW-1:0] sat_col(input logic [SW-1:0] v);
    sat_col = (v > LIMIT) ? LIMIT[CW-1:0] : v[CW-1:0];
  endfunction

  // effective tab width clamped to the supported range
  always_comb begin
    if (tw_q < brtc_pkg::TW_MIN) begin
      width = brtc_pkg::TW_MIN;
    end else if (tw_q > brtc_pkg::TW_MAX) begin
      width = brtc_pkg::TW_MAX;
    end else begin
      width = tw_q;
    end
  end

  // input word classes
  assign in_nl    = (in_char_i == brtc_pkg::CH_NEWLINE);
  assign in_tab   = (in_char_i == brtc_pkg::CH_TAB);
  assign in_space = (in_char_i == brtc_pkg::CH_SPACE);

  // remainder of the column for a tab, of the run start for a flush
  assign mod_dvd = in_tab ? col_q : bstart_q;

  brtc_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (width),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  // next tab stops and column increment
  assign col_tab  = SW'(col_q) + SW'(width) - SW'(rem);
  assign run_stop = SW'(bstart_q) + SW'(width) - SW'(rem);
  assign col_inc  = SW'(col_q) + SW'(1);

  // flush decisions
  assign tab_due   = (stop_q <= SW'(col_q));
  assign space_due = (pos_q < col_q);

  always_comb begin
    tw_d     = cfg_we_i ? cfg_wdata_i : tw_q;
    col_d    = col_q;
    run_d    = run_q;
    bstart_d = bstart_q;
    pos_d    = pos_q;
    stop_d   = stop_q;
    char_d   = char_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    ovalid_d = out_ready_i ? 1'b0 : ovalid_q;

    // input word taken
    if (cmd_i.accept) begin
      if (in_nl) begin
        col_d    = '0;
        run_d    = 1'b0;
        bstart_d = '0;
        char_d   = in_char_i;
        pos_d    = '0;
        stop_d   = STOP_OFF;
      end else if (in_tab || in_space) begin
        if (!run_q) begin
          run_d    = 1'b1;
          bstart_d = col_q;
        end
        if (in_space) begin
          col_d = sat_col(col_inc);
        end
      end else begin
        char_d = in_char_i;
        if (!run_q) begin
          pos_d  = col_q;
          stop_d = STOP_OFF;
        end
      end
    end

    // tab finished its remainder
    if (cmd_i.tab_finish) begin
      col_d = sat_col(col_tab);
    end

    // flush cursor from the start of the run
    if (cmd_i.flush_setup) begin
      run_d  = 1'b0;
      pos_d  = bstart_q;
      stop_d = run_stop;
    end

    // one output word: tab, space or the held character
    if (cmd_i.emit) begin
      ovalid_d = 1'b1;
      if (tab_due) begin
        ochar_d = brtc_pkg::CH_TAB;
        olast_d = 1'b0;
        pos_d   = stop_q[CW-1:0];
        stop_d  = stop_q + SW'(width);
      end else if (space_due) begin
        ochar_d = brtc_pkg::CH_SPACE;
        olast_d = 1'b0;
        pos_d   = pos_q + 1'b1;
      end else begin
        ochar_d = char_q;
        olast_d = 1'b1;
        if (char_q != brtc_pkg::CH_NEWLINE) begin
          col_d = sat_col(col_inc);
        end
      end
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q     <= brtc_pkg::TW_RESET;
      col_q    <= '0;
      run_q    <= 1'b0;
      bstart_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      tw_q     <= tw_d;
      col_q    <= col_d;
      run_q    <= run_d;
      bstart_q <= bstart_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    stop_q  <= stop_d;
    char_q  <= char_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign status_o.in_nl      = in_nl;
  assign status_o.in_tab     = in_tab;
  assign status_o.in_space   = in_space;
  assign status_o.in_run     = run_q;
  assign status_o.mod_done   = mod_done;
  assign status_o.out_free   = !ovalid_q || out_ready_i;
  assign status_o.emit_final = !tab_due && !space_due;

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

endmodule

>>> rtl/core/brtc_ctrl.sv
// controller: sequences accept, remainder wait and flush emission
module brtc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  brtc_pkg::dp_status_t  status_i,
  output brtc_pkg::ctrl_cmd_t   cmd_o
);

  brtc_pkg::state_e state_q, state_d;
  logic             is_other;

  assign is_other = !status_i.in_nl && !status_i.in_tab && !status_i.in_space;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      brtc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_nl) begin
            state_d = brtc_pkg::ST_FLUSH;
          end else if (status_i.in_tab) begin
            state_d = brtc_pkg::ST_MOD_TAB;
          end else if (is_other) begin
            state_d = status_i.in_run ? brtc_pkg::ST_MOD_FLUSH : brtc_pkg::ST_FLUSH;
          end
        end
      end
      brtc_pkg::ST_MOD_TAB: begin
        if (status_i.mod_done) begin
          state_d = brtc_pkg::ST_IDLE;
        end
      end
      brtc_pkg::ST_MOD_FLUSH: begin
        if (status_i.mod_done) begin
          state_d = brtc_pkg::ST_FLUSH;
        end
      end
      brtc_pkg::ST_FLUSH: begin
        if (status_i.out_free && status_i.emit_final) begin
          state_d = brtc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = brtc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    case (state_q)
      brtc_pkg::ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.accept     = in_valid_i;
        cmd_o.mod_start  = in_valid_i &&
                           (status_i.in_tab || (is_other && status_i.in_run));
      end
      brtc_pkg::ST_MOD_TAB: begin
        cmd_o.tab_finish = status_i.mod_done;
      end
      brtc_pkg::ST_MOD_FLUSH: begin
        cmd_o.flush_setup = status_i.mod_done;
      end
      brtc_pkg::ST_FLUSH: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brtc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/brtc_checker.sv
// port-level checker for the blank run compressor, bound to the top level
`include "blank_run_to_tab_compressor_core_macros.svh"

module brtc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [brtc_pkg::CHAR_W-1:0]  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [brtc_pkg::CHAR_W-1:0]  m_axis_tdata,
  input  logic                         m_axis_tlast
);

  logic s_take;
  assign s_take = s_axis_tvalid && s_axis_tready;

  // a stalled output word holds
  `BRTC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // words before the closing one are always tabs or spaces
  `BRTC_ASSERT_IMP(a_mid_blank, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tdata == brtc_pkg::CH_TAB || m_axis_tdata == brtc_pkg::CH_SPACE)

  // a newline is never followed by more words for the same input
  `BRTC_ASSERT_IMP(a_nl_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata == brtc_pkg::CH_NEWLINE, m_axis_tlast)

  // a space only moves the column, so the input side stays open
  `BRTC_ASSERT_NXT(a_space_ready, clk_i, rst_ni, s_take && s_axis_tdata == brtc_pkg::CH_SPACE, s_axis_tready)

  // a newline must be emitted before the next word is taken
  `BRTC_ASSERT_NXT(a_nl_busy, clk_i, rst_ni, s_take && s_axis_tdata == brtc_pkg::CH_NEWLINE, !s_axis_tready)

endmodule

bind blank_run_to_tab_compressor_core brtc_checker u_brtc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> verif/tb.sv
// testbench for the blank run to tab compressor: directed and random text against a predictor
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 70;

  typedef struct packed {
    logic [brtc_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } out_word_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we_i      = 1'b0;
  logic [brtc_pkg::TW_W-1:0]   cfg_wdata_i   = brtc_pkg::TW_RESET;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [brtc_pkg::CHAR_W-1:0] s_axis_tdata  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [brtc_pkg::CHAR_W-1:0] m_axis_tdata;
  logic                        m_axis_tlast;

  // predictor state
  out_word_t                 expected_words[$];
  logic [brtc_pkg::TW_W-1:0] stop_gap_q  = brtc_pkg::TW_RESET;
  int unsigned               col_now     = 0;
  bit                        run_pending = 1'b0;
  int unsigned               run_start   = 0;

  bit          src_idle     = 1'b1;
  bit          snk_idle     = 1'b1;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count   = 0;

  blank_run_to_tab_compressor_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // out-of-range widths act as the nearest legal one
  function automatic int unsigned clamp_width(logic [brtc_pkg::TW_W-1:0] v);
    if (v < brtc_pkg::TW_MIN) return 32'(brtc_pkg::TW_MIN);
    if (v > brtc_pkg::TW_MAX) return 32'(brtc_pkg::TW_MAX);
    return 32'(v);
  endfunction

  function automatic int unsigned stop_after(int unsigned c, int unsigned w);
    return c + (w - (c % w));
  endfunction

  function automatic int unsigned cap_column(int unsigned v);
    return (v > brtc_pkg::COLUMN_LIMIT_DEF) ? brtc_pkg::COLUMN_LIMIT_DEF : v;
  endfunction

  // work out the words one accepted character gives and advance the column
  task automatic entab_char(input logic [brtc_pkg::CHAR_W-1:0] c);
    int unsigned w;
    int unsigned pos;
    w = clamp_width(stop_gap_q);
    if (c == brtc_pkg::CH_NEWLINE) begin
      expected_words.push_back('{ch: brtc_pkg::CH_NEWLINE, last: 1'b1});
      col_now     = 0;
      run_pending = 1'b0;
      run_start   = 0;
    end else if (c == brtc_pkg::CH_TAB || c == brtc_pkg::CH_SPACE) begin
      if (!run_pending) begin
        run_pending = 1'b1;
        run_start   = col_now;
      end
      col_now = (c == brtc_pkg::CH_TAB) ? cap_column(stop_after(col_now, w))
                                        : cap_column(col_now + 1);
    end else begin
      // flush the pending run: tabs as far as they go, then spaces
      if (run_pending) begin
        pos         = run_start;
        run_pending = 1'b0;
        while (stop_after(pos, w) <= col_now) begin
          expected_words.push_back('{ch: brtc_pkg::CH_TAB, last: 1'b0});
          pos = stop_after(pos, w);
        end
        while (pos < col_now) begin
          expected_words.push_back('{ch: brtc_pkg::CH_SPACE, last: 1'b0});
          pos++;
        end
      end
      expected_words.push_back('{ch: c, last: 1'b1});
      col_now = cap_column(col_now + 1);
    end
  endtask

  // sink side back-pressure
  always @(posedge clk_i) begin
    int unsigned gap_len;
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      gap_len = snk_idle ? pick_gap() : 0;
      m_axis_tready <= (gap_len == 0);
      stall_left = (gap_len == 0) ? 0 : gap_len - 1;
    end
  end

  // compare each output word with the oldest expectation
  always @(negedge clk_i) begin
    out_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_char 0x%02h last %0b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $error("out_char mismatch: expected 0x%02h, got 0x%02h", want.ch, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offer one character and wait for it to be taken; returns on the accepting edge
  task automatic send_char(input logic [brtc_pkg::CHAR_W-1:0] c);
    int unsigned gap_len;
    gap_len = src_idle ? pick_gap() : 0;
    if (gap_len != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    entab_char(c);
  endtask

  // let every expected word out, then give a trailing tab time to finish
  task automatic wait_quiet();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_stop_gap(input logic [brtc_pkg::TW_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    stop_gap_q = v;
  endtask

  // short text at the reset width: byte extremes, lone blanks, mixed runs, dropped runs
  task automatic test_directed();
    logic [brtc_pkg::CHAR_W-1:0] text [19];
    text = '{8'h41, 8'h00, 8'hff, brtc_pkg::CH_NEWLINE,
             brtc_pkg::CH_SPACE, 8'h62,
             brtc_pkg::CH_TAB, 8'h63,
             brtc_pkg::CH_SPACE, brtc_pkg::CH_SPACE, brtc_pkg::CH_SPACE,
             brtc_pkg::CH_TAB, brtc_pkg::CH_SPACE, 8'h64,
             brtc_pkg::CH_TAB, brtc_pkg::CH_TAB, brtc_pkg::CH_NEWLINE,
             brtc_pkg::CH_TAB, 8'h65};
    foreach (text[i]) send_char(text[i]);
  endtask

  // random lines, a quarter of them long and tab heavy so the column saturates
  task automatic test_random_text(input logic [brtc_pkg::TW_W-1:0] width, input bit src_gaps,
                                  input bit snk_gaps, input int unsigned n_items);
    int unsigned                 line_left;
    bit                          long_line;
    int unsigned                 r;
    logic [brtc_pkg::CHAR_W-1:0] c;
    write_stop_gap(width);
    src_idle  = src_gaps;
    snk_idle  = snk_gaps;
    line_left = 0;
    long_line = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (line_left == 0) begin
        c         = brtc_pkg::CH_NEWLINE;
        long_line = ($urandom_range(0, 3) == 0);
        line_left = long_line ? $urandom_range(30, 70) : $urandom_range(1, 25);
      end else begin
        line_left--;
        r = $urandom_range(0, 99);
        if (long_line)
          c = (r < 45) ? brtc_pkg::CH_TAB : (r < 60) ? brtc_pkg::CH_SPACE :
              brtc_pkg::CHAR_W'($urandom_range(0, 255));
        else
          c = (r < 25) ? brtc_pkg::CH_SPACE : (r < 35) ? brtc_pkg::CH_TAB :
              (r < 37) ? brtc_pkg::CH_NEWLINE : brtc_pkg::CHAR_W'($urandom_range(0, 255));
      end
      send_char(c);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_text(5'd0,  1'b1, 1'b1, PHASE_ITEMS);
    test_random_text(5'd31, 1'b1, 1'b1, PHASE_ITEMS);
    test_random_text(brtc_pkg::TW_MIN, 1'b0, 1'b0, PHASE_ITEMS);
    test_random_text(brtc_pkg::TW_MAX, 1'b0, 1'b1, PHASE_ITEMS);
    test_random_text(5'd12, 1'b1, 1'b0, PHASE_ITEMS);
    test_random_text(brtc_pkg::TW_W'($urandom_range(0, 31)), 1'b1, 1'b1, PHASE_ITEMS);

    s_axis_tvalid <= 1'b0;
    wait_quiet();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
